@@ rtl/hrpc_pkg.sv @@
// Shared types, constants and elaboration-time functions for the HEALPix
// ring point coordinate pipeline. No dependencies.
package hrpc_pkg;

	localparam int MAX_NSIDE   = 8192;
	localparam int FRAC_BITS   = 24;
	localparam int TURN_BITS   = 48;
	localparam int CORDIC_STEPS = 48;
	localparam int VEC_BITS    = 50;
	localparam int SQRT_STEPS  = 50;
	localparam int DIV_STEPS   = 33;
	localparam int SERIES_BITS = 60;

	// Register indices (register index is paddr[2]).
	localparam logic REG_NSIDE = 1'b0;

	// Per-item flags that travel alongside the data.
	typedef struct packed {
		logic        ok;
		logic        south;
		logic        equator;
		logic [15:0] count;
	} side_t;

	// Number of significant bits of a 28-bit value.
	function automatic logic [5:0] bit_len(input logic [27:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) begin
				n = 6'(i + 1);
			end
		end
		return n;
	endfunction

	// pi/4 scaled by 2^60 through Machin's formula.
	function automatic logic [63:0] machin_quarter_pi();
		logic [63:0] p;
		logic [63:0] term;
		logic [63:0] s5;
		logic [63:0] s239;
		int unsigned k;
		p = (64'd1 << SERIES_BITS) / 64'd5;
		s5 = '0;
		k = 0;
		while (p != 64'd0) begin
			term = p / 64'(2 * k + 1);
			if ((k % 2) != 0) s5 = s5 - term;
			else s5 = s5 + term;
			p = p / 64'd25;
			k++;
		end
		p = (64'd1 << SERIES_BITS) / 64'd239;
		s239 = '0;
		k = 0;
		while (p != 64'd0) begin
			term = p / 64'(2 * k + 1);
			if ((k % 2) != 0) s239 = s239 - term;
			else s239 = s239 + term;
			p = p / 64'd57121;
			k++;
		end
		return 64'd4 * s5 - s239;
	endfunction

	// atan(2^-i) scaled by 2^60, for i of at least one.
	function automatic logic [63:0] atan_pow2(input int unsigned i);
		logic [63:0] p;
		logic [63:0] term;
		logic [63:0] sum;
		int unsigned k;
		p = 64'd1 << (SERIES_BITS - i);
		sum = '0;
		k = 0;
		while (p != 64'd0) begin
			term = p / 64'(2 * k + 1);
			if ((k % 2) != 0) sum = sum - term;
			else sum = sum + term;
			p = p >> (2 * i);
			k++;
		end
		return sum;
	endfunction

	// Arctangent table entry i in turns with TURN_BITS fraction bits.
	function automatic logic [63:0] atan_rom_entry(input int unsigned i);
		logic [63:0] qp;
		logic [63:0] full;
		logic [63:0] r;
		logic [63:0] q;
		qp = machin_quarter_pi();
		full = qp * 64'd8;
		r = (i == 0) ? qp : atan_pow2(i);
		q = '0;
		for (int t = 0; t <= TURN_BITS; t++) begin
			r = r << 1;
			q = q << 1;
			if (r >= full) begin
				r = r - full;
				q = q | 64'd1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

endpackage

@@ rtl/healpix_ring_point_coordinates.sv @@
// HEALPix ring-scheme point coordinate pipeline: decode, vector setup,
// integer square root, CORDIC vectoring, longitude divider. Uses hrpc_pkg.
//
// Usage: write nside through the APB port (byte address 0) while the block
// is idle, then stream transactions of (ring_index, point_index) on the input
// channel. Each accepted transaction yields one result transaction with
// latitude, longitude, ring_points and in_range; requests outside the grid
// return in_range low and all other fields zero.
// The pipeline has 106 register stages. One transaction is accepted per cycle
// while the output is not stalled; the length is set by the 50 one-bit square
// root stages and the 48 CORDIC stages. The 33-step longitude divider runs
// beside the square root.
// The whole pipeline advances on one enable: when out_valid is high and
// out_ready is low, every stage holds and in_ready drops; nothing is dropped
// or repeated. Reset clears all stage valid bits and sets nside to 1.
module healpix_ring_point_coordinates (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [14:0]        ring_index,
	input  logic [14:0]        point_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] latitude,
	output logic [32:0]        longitude,
	output logic [15:0]        ring_points,
	output logic               in_range
);

	localparam int SQ = hrpc_pkg::SQRT_STEPS;
	localparam int CD = hrpc_pkg::CORDIC_STEPS;
	localparam int DV = hrpc_pkg::DIV_STEPS;

	logic [13:0] nside_q;
	logic        adv;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nside_q <= 14'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == hrpc_pkg::REG_NSIDE) begin
			nside_q <= pwdata[13:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == hrpc_pkg::REG_NSIDE) ? {18'd0, nside_q} : 32'd0;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- Stage 1: request decode ----------------
	logic [16:0] n17, j17, p17, cnt17, k17;
	logic        bad_n, ring_ok, south_d, h_d;
	logic [13:0] r_d;

	always_comb begin
		n17 = {3'd0, nside_q};
		j17 = {2'd0, ring_index};
		p17 = {2'd0, point_index};
		bad_n = (nside_q == 14'd0) || (n17 > 17'(hrpc_pkg::MAX_NSIDE));
		ring_ok = j17 <= (4 * n17 - 17'd2);
		if (j17 < n17) cnt17 = 4 * (j17 + 17'd1);
		else if (j17 < 3 * n17) cnt17 = 4 * n17;
		else cnt17 = 4 * (4 * n17 - 17'd1 - j17);
		south_d = j17 >= 2 * n17;
		k17 = south_d ? (4 * n17 - 17'd2 - j17) : j17;
		r_d = 14'(k17 + 17'd1);
		h_d = (j17 < n17) || (j17 > 3 * n17 - 17'd1) || ((j17[0] ^ n17[0]) == 1'b1);
	end

	logic                vld_s1;
	logic [13:0]         n_s1, r_s1;
	logic [15:0]         a_s1;
	logic                polar_s1;
	hrpc_pkg::side_t     side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= nside_q;
			r_s1 <= r_d;
			a_s1 <= {point_index, h_d};
			polar_s1 <= r_d < nside_q;
			side_s1.ok <= !bad_n && ring_ok && (p17 < cnt17);
			side_s1.south <= south_d;
			side_s1.equator <= j17 == (2 * n17 - 17'd1);
			side_s1.count <= cnt17[15:0];
		end
	end

	// ---------------- Stage 2: squares ----------------
	logic                vld_s2;
	logic [27:0]         nn_s2, rr_s2;
	logic [23:0]         a180_s2;
	logic [13:0]         n_s2, r_s2;
	logic                polar_s2;
	hrpc_pkg::side_t     side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nn_s2 <= 28'(n_s1) * 28'(n_s1);
			rr_s2 <= 28'(r_s1) * 28'(r_s1);
			a180_s2 <= 24'(a_s1) * 24'd180;
			n_s2 <= n_s1;
			r_s2 <= r_s1;
			polar_s2 <= polar_s1;
			side_s2 <= side_s1;
		end
	end

	// ---------------- Stage 3: vector terms ----------------
	logic                vld_s3;
	logic [27:0]         x_s3, m_s3, mulb_s3;
	logic [28:0]         mula_s3;
	logic [29:0]         nn9_s3;
	logic [23:0]         a180_s3;
	logic                polar_s3;
	hrpc_pkg::side_t     side_s3;
	logic [15:0]         xe_d;

	assign xe_d = 16'(4 * {2'd0, n_s2}) - 16'(2 * {2'd0, r_s2});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (polar_s2) begin
				x_s3 <= 28'(3 * nn_s2) - rr_s2;
				m_s3 <= 28'(3 * nn_s2);
				mula_s3 <= 29'(6 * 29'(nn_s2)) - 29'(rr_s2);
				mulb_s3 <= rr_s2;
			end else begin
				x_s3 <= 28'(xe_d);
				m_s3 <= 28'(3 * 28'(n_s2));
				mula_s3 <= 29'(xe_d);
				mulb_s3 <= 28'(xe_d);
			end
			nn9_s3 <= 30'(9 * 30'(nn_s2));
			a180_s3 <= a180_s2;
			polar_s3 <= polar_s2;
			side_s3 <= side_s2;
		end
	end

	// ---------------- Stage 4: product ----------------
	logic                vld_s4;
	logic [56:0]         prod_s4;
	logic [27:0]         x_s4, m_s4;
	logic [29:0]         nn9_s4;
	logic [23:0]         a180_s4;
	logic                polar_s4;
	hrpc_pkg::side_t     side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= 57'(mula_s3) * 57'(mulb_s3);
			x_s4 <= x_s3;
			m_s4 <= m_s3;
			nn9_s4 <= nn9_s3;
			a180_s4 <= a180_s3;
			polar_s4 <= polar_s3;
			side_s4 <= side_s3;
		end
	end

	// ---------------- Stage 5: radicand and scale ----------------
	logic                vld_s5;
	logic [55:0]         d_s5;
	logic [5:0]          s_s5;
	logic [27:0]         x_s5;
	logic [23:0]         a180_s5;
	hrpc_pkg::side_t     side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s5 <= polar_s4 ? prod_s4[55:0] : (56'(nn9_s4) - prod_s4[55:0]);
			s_s5 <= 6'(hrpc_pkg::VEC_BITS) - hrpc_pkg::bit_len(m_s4);
			x_s5 <= x_s4;
			a180_s5 <= a180_s4;
			side_s5 <= side_s4;
		end
	end

	// ---------------- Stage 6: normalize ----------------
	logic                vld_s6;
	logic [99:0]         dd_s6;
	logic [49:0]         xx_s6;
	logic [47:0]         num_s6;
	hrpc_pkg::side_t     side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else if (adv) vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s6 <= 100'(d_s5) << {s_s5, 1'b0};
			xx_s6 <= 50'(x_s5) << s_s5;
			// Rounded dividend: angle numerator plus half the divisor.
			num_s6 <= {a180_s5, 9'd0, side_s5.count[15:1]};
			side_s6 <= side_s5;
		end
	end

	// ---------------- Square root and longitude divider ----------------
	logic                sq_vld_s  [1:SQ];
	logic [51:0]         sq_rem_s  [1:SQ];
	logic [49:0]         sq_root_s [1:SQ];
	logic [99:0]         sq_dd_s   [1:SQ];
	logic [49:0]         sq_xx_s   [1:SQ];
	logic [15:0]         dv_rem_s  [1:SQ];
	logic [32:0]         dv_bits_s [1:SQ];
	logic [32:0]         dv_q_s    [1:SQ];
	hrpc_pkg::side_t     sq_side_s [1:SQ];

	for (genvar i = 0; i < SQ; i++) begin : g_sqrt
		logic            vld_in;
		logic [51:0]     rem_in;
		logic [49:0]     root_in;
		logic [99:0]     dd_in;
		logic [49:0]     xx_in;
		logic [15:0]     drem_in;
		logic [32:0]     dbits_in;
		logic [32:0]     dq_in;
		hrpc_pkg::side_t side_in;
		logic [53:0]     t;
		logic [53:0]     trial;
		logic            ge;

		if (i == 0) begin : g_first
			assign vld_in = vld_s6;
			assign rem_in = '0;
			assign root_in = '0;
			assign dd_in = dd_s6;
			assign xx_in = xx_s6;
			assign drem_in = {1'b0, num_s6[47:33]};
			assign dbits_in = num_s6[32:0];
			assign dq_in = '0;
			assign side_in = side_s6;
		end else begin : g_next
			assign vld_in = sq_vld_s[i];
			assign rem_in = sq_rem_s[i];
			assign root_in = sq_root_s[i];
			assign dd_in = sq_dd_s[i];
			assign xx_in = sq_xx_s[i];
			assign drem_in = dv_rem_s[i];
			assign dbits_in = dv_bits_s[i];
			assign dq_in = dv_q_s[i];
			assign side_in = sq_side_s[i];
		end

		assign t = {rem_in, dd_in[99:98]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[i+1] <= 1'b0;
			else if (adv) sq_vld_s[i+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem_s[i+1] <= ge ? 52'(t - trial) : t[51:0];
				sq_root_s[i+1] <= {root_in[48:0], ge};
				sq_dd_s[i+1] <= dd_in << 2;
				sq_xx_s[i+1] <= xx_in;
				sq_side_s[i+1] <= side_in;
			end
		end

		if (i < DV) begin : g_div
			logic [16:0] dt;
			logic        dge;
			assign dt = {drem_in, dbits_in[32]};
			assign dge = dt >= {1'b0, side_in.count};
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[i+1] <= dge ? 16'(dt - {1'b0, side_in.count}) : dt[15:0];
					dv_bits_s[i+1] <= dbits_in << 1;
					dv_q_s[i+1] <= {dq_in[31:0], dge};
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem_s[i+1] <= drem_in;
					dv_bits_s[i+1] <= dbits_in;
					dv_q_s[i+1] <= dq_in;
				end
			end
		end
	end

	// ---------------- CORDIC vectoring ----------------
	logic                cd_vld_s  [1:CD];
	logic signed [52:0]  cd_x_s    [1:CD];
	logic signed [52:0]  cd_y_s    [1:CD];
	logic signed [49:0]  cd_z_s    [1:CD];
	logic [32:0]         cd_lon_s  [1:CD];
	hrpc_pkg::side_t     cd_side_s [1:CD];

	for (genvar i = 0; i < CD; i++) begin : g_cordic
		localparam logic signed [49:0] ROM_I = 50'(hrpc_pkg::atan_rom_entry(i));
		logic               vld_in;
		logic signed [52:0] x_in, y_in, y_abs;
		logic signed [49:0] z_in;
		logic [32:0]        lon_in;
		hrpc_pkg::side_t    side_in;

		if (i == 0) begin : g_first
			assign vld_in = sq_vld_s[SQ];
			assign x_in = {3'd0, sq_root_s[SQ]};
			assign y_in = {3'd0, sq_xx_s[SQ]};
			assign z_in = '0;
			assign lon_in = dv_q_s[SQ];
			assign side_in = sq_side_s[SQ];
		end else begin : g_next
			assign vld_in = cd_vld_s[i];
			assign x_in = cd_x_s[i];
			assign y_in = cd_y_s[i];
			assign z_in = cd_z_s[i];
			assign lon_in = cd_lon_s[i];
			assign side_in = cd_side_s[i];
		end

		// Arithmetic shifts round toward minus infinity, so the negative y uses its magnitude to truncate toward zero.
		assign y_abs = y_in[52] ? -y_in : y_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cd_vld_s[i+1] <= 1'b0;
			else if (adv) cd_vld_s[i+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				cd_x_s[i+1] <= x_in + (y_abs >>> i);
				if (y_in[52]) begin
					cd_y_s[i+1] <= y_in + (x_in >>> i);
					cd_z_s[i+1] <= z_in - ROM_I;
				end else begin
					cd_y_s[i+1] <= y_in - (x_in >>> i);
					cd_z_s[i+1] <= z_in + ROM_I;
				end
				cd_lon_s[i+1] <= lon_in;
				cd_side_s[i+1] <= side_in;
			end
		end
	end

	// ---------------- Stage 7: clamp and scale to degrees ----------------
	localparam logic signed [49:0] QUARTER = 50'sd1 <<< (hrpc_pkg::TURN_BITS - 2);

	logic                vld_s7;
	logic [55:0]         deg_s7;
	logic [32:0]         lon_s7;
	hrpc_pkg::side_t     side_s7;
	logic [46:0]         zc;

	always_comb begin
		if (cd_z_s[CD][49]) zc = '0;
		else if (cd_z_s[CD] > QUARTER) zc = QUARTER[46:0];
		else zc = cd_z_s[CD][46:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else if (adv) vld_s7 <= cd_vld_s[CD];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s7 <= 56'(zc) * 56'd360;
			lon_s7 <= cd_lon_s[CD];
			side_s7 <= cd_side_s[CD];
		end
	end

	// ---------------- Stage 8: rounding and output register ----------------
	localparam int RND_SH = hrpc_pkg::TURN_BITS - hrpc_pkg::FRAC_BITS;

	logic                vld_s8;
	logic signed [31:0]  lat_s8;
	logic [32:0]         lon_s8;
	logic [15:0]         cnt_s8;
	logic                ok_s8;
	logic [55:0]         deg_rnd;

	assign deg_rnd = deg_s7 + (56'd1 << (RND_SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else if (adv) vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (!side_s7.ok) begin
				lat_s8 <= '0;
				lon_s8 <= '0;
				cnt_s8 <= '0;
				ok_s8 <= 1'b0;
			end else begin
				if (side_s7.equator) lat_s8 <= '0;
				else if (side_s7.south) lat_s8 <= -$signed(deg_rnd[RND_SH +: 32]);
				else lat_s8 <= $signed(deg_rnd[RND_SH +: 32]);
				lon_s8 <= lon_s7;
				cnt_s8 <= side_s7.count;
				ok_s8 <= 1'b1;
			end
		end
	end

	assign out_valid   = vld_s8;
	assign latitude    = lat_s8;
	assign longitude   = lon_s8;
	assign ring_points = cnt_s8;
	assign in_range    = ok_s8;

	// ---------------- Assertions ----------------
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> latitude == 32'sd0 && longitude == 33'd0 && ring_points == 16'd0)
		else $error("invalid request produced nonzero fields");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> longitude < 33'd6039797760 && ring_points != 16'd0)
		else $error("longitude or ring count out of range");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_range |-> latitude <= 32'sd1509949440 && latitude >= -32'sd1509949440)
		else $error("latitude out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(vld_s1) && $stable(vld_s7))
		else $error("pipeline moved during a stall");

endmodule

@@ tb/tb_healpix_ring_point_coordinates.sv @@
// Testbench for healpix_ring_point_coordinates: streams ring/point requests under
// several grid resolutions and checks every result against an in-bench predictor.
// Depends on hrpc_pkg and the healpix_ring_point_coordinates RTL.
module tb_healpix_ring_point_coordinates;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] lat;
		logic [32:0]        lon;
		logic [15:0]        pts;
		logic               ok;
	} coord_t;

	class coord_scoreboard;
		longint unsigned nside_val;
		longint unsigned atan_turns[48];
		coord_t          pending[$];
		bit              failed;

		function new();
			longint unsigned qpi, full, a;
			nside_val = 1;
			failed = 0;
			qpi = 4 * recip_series(5) - recip_series(239);
			full = qpi * 8;
			for (int i = 0; i < 48; i++) begin
				a = (i == 0) ? qpi : pow2_series(i);
				atan_turns[i] = to_turns(a, full);
			end
		endfunction

		function longint unsigned recip_series(longint unsigned m);
			longint unsigned p, sum, term;
			int unsigned k;
			p = (64'd1 << 60) / m;
			sum = 0;
			k = 0;
			while (p != 0) begin
				term = p / (2 * k + 1);
				if (k & 1) sum -= term;
				else sum += term;
				p = p / (m * m);
				k++;
			end
			return sum;
		endfunction

		function longint unsigned pow2_series(int unsigned i);
			longint unsigned p, sum, term;
			int unsigned k;
			p = 64'd1 << (60 - i);
			sum = 0;
			k = 0;
			while (p != 0) begin
				term = p / (2 * k + 1);
				if (k & 1) sum -= term;
				else sum += term;
				p = (2 * i >= 64) ? 0 : (p >> (2 * i));
				k++;
			end
			return sum;
		endfunction

		function longint unsigned to_turns(longint unsigned a, longint unsigned full);
			longint unsigned r, q;
			r = a;
			q = 0;
			for (int t = 0; t <= 48; t++) begin
				r = r << 1;
				q = q << 1;
				if (r >= full) begin
					r -= full;
					q |= 1;
				end
			end
			return (q + 1) >> 1;
		endfunction

		function int unsigned nbits(longint unsigned v);
			int unsigned c;
			c = 0;
			while (v != 0) begin
				c++;
				v >>= 1;
			end
			return c;
		endfunction

		// Bitwise floor(sqrt(d * 4^s)).
		function longint unsigned root_scaled(longint unsigned d, int unsigned s);
			longint unsigned root, rem, pr, trial;
			root = 0;
			rem = 0;
			for (int unsigned p = 0; p < 32 + s; p++) begin
				pr = 0;
				if (p < 32) pr = (d >> (62 - 2 * p)) & 3;
				rem = (rem << 2) | pr;
				trial = (root << 2) | 1;
				if (rem >= trial) begin
					rem -= trial;
					root = (root << 1) | 1;
				end else begin
					root = root << 1;
				end
			end
			return root;
		endfunction

		function longint trunc_shift(longint v, int unsigned i);
			if (v >= 0) return v >>> i;
			return -((-v) >>> i);
		endfunction

		function longint lat_degrees(longint unsigned n, longint unsigned j);
			bit south;
			longint unsigned k, r, x, d, m, deg;
			int unsigned s;
			longint cx, cy, z, dx, dy;
			if (j == 2 * n - 1) return 0;
			south = (j >= 2 * n);
			k = south ? (4 * n - 2 - j) : j;
			r = k + 1;
			if (r < n) begin
				x = 3 * n * n - r * r;
				d = r * r * (6 * n * n - r * r);
				m = 3 * n * n;
			end else begin
				x = 4 * n - 2 * r;
				d = 9 * n * n - x * x;
				m = 3 * n;
			end
			s = 50 - nbits(m);
			cx = root_scaled(d, s);
			cy = x << s;
			z = 0;
			for (int unsigned i = 0; i < 48; i++) begin
				dx = trunc_shift(cy, i);
				dy = trunc_shift(cx, i);
				if (cy >= 0) begin
					cx += dx;
					cy -= dy;
					z += atan_turns[i];
				end else begin
					cx -= dx;
					cy += dy;
					z -= atan_turns[i];
				end
			end
			if (z < 0) z = 0;
			if (z > (64'sd1 << 46)) z = 64'sd1 << 46;
			deg = (longint'(z) * 360 + (64'd1 << 23)) >> 24;
			return south ? -longint'(deg) : longint'(deg);
		endfunction

		function void note_request(longint unsigned j, longint unsigned p);
			coord_t e;
			longint unsigned n, cnt, h, num;
			n = nside_val;
			e = '{lat: 0, lon: 0, pts: 0, ok: 0};
			if (n != 0 && n <= hrpc_pkg::MAX_NSIDE && j <= 4 * n - 2) begin
				if (j < n) cnt = 4 * (j + 1);
				else if (j < 3 * n) cnt = 4 * n;
				else cnt = 4 * (4 * n - 1 - j);
				if (p < cnt) begin
					h = (j < n || j > 3 * n - 1 || ((j + n) & 1)) ? 1 : 0;
					num = (2 * p + h) * 180 * (64'd1 << 24);
					e.lat = 32'(lat_degrees(n, j));
					e.lon = 33'((num + cnt / 2) / cnt);
					e.pts = 16'(cnt);
					e.ok = 1;
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(logic signed [31:0] lat, logic [32:0] lon,
				logic [15:0] pts, logic ok);
			coord_t e;
			if (pending.size() == 0) begin
				$error("result transaction with no request outstanding");
				failed = 1;
				return;
			end
			e = pending.pop_front();
			if (lat !== e.lat) begin
				$error("latitude: expected %0d, got %0d", e.lat, lat);
				failed = 1;
			end
			if (lon !== e.lon) begin
				$error("longitude: expected %0d, got %0d", e.lon, lon);
				failed = 1;
			end
			if (pts !== e.pts) begin
				$error("ring_points: expected %0d, got %0d", e.pts, pts);
				failed = 1;
			end
			if (ok !== e.ok) begin
				$error("in_range: expected %0d, got %0d", e.ok, ok);
				failed = 1;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic [14:0] ring_index = '0, point_index = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] latitude;
	logic [32:0] longitude;
	logic [15:0] ring_points;
	logic in_range;

	coord_scoreboard sb = new();
	int unsigned cycle_count = 0;
	int unsigned hold_request = 0;
	bit tx_quiet = 0, rx_quiet = 0;

	healpix_ring_point_coordinates uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready) sb.note_request(ring_index, point_index);
		if (out_valid && out_ready)
			sb.check_result(latitude, longitude, ring_points, in_range);
	end

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			if (hold_request != 0) begin
				stall = hold_request;
				hold_request = 0;
			end else begin
				stall = rx_quiet ? 0 : $urandom_range(0, 11);
			end
			if (stall > 0) begin
				out_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic write_nside(logic [31:0] value);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {hrpc_pkg::REG_NSIDE, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.nside_val = value & 32'h3FFF;
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic send_request(logic [14:0] j, logic [14:0] p);
		int unsigned gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		ring_index <= j;
		point_index <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic int unsigned points_on(int unsigned n, int unsigned j);
		if (j < n) return 4 * (j + 1);
		if (j < 3 * n) return 4 * n;
		return 4 * (4 * n - 1 - j);
	endfunction

	task automatic run_phase(logic [31:0] value, int unsigned count, bit long_hold);
		int unsigned n, j, p;
		write_nside(value);
		n = value & 32'h3FFF;
		if (long_hold) hold_request = 600;
		if (n >= 1 && n <= hrpc_pkg::MAX_NSIDE) begin
			// Poles, polar/equatorial boundaries, equator, and out-of-range cases.
			send_request(0, 0);
			send_request(0, 3);
			send_request(0, 4);
			send_request(n - 1, points_on(n, n - 1) - 1);
			send_request(n, 0);
			send_request(2 * n - 1, 1);
			send_request(3 * n - 1, 0);
			send_request(3 * n, 2);
			send_request(4 * n - 2, 3);
			send_request(4 * n - 2, 4);
			if (4 * n - 1 <= 32767) send_request(4 * n - 1, 0);
			send_request(2 * n, points_on(n, 2 * n) - 1);
			send_request(2 * n, points_on(n, 2 * n));
		end
		send_request(15'h7FFF, 15'h7FFF);
		for (int i = 0; i < count; i++) begin
			if (n >= 1 && n <= hrpc_pkg::MAX_NSIDE && $urandom_range(0, 99) < 85) begin
				j = $urandom_range(0, 4 * n - 2);
				p = $urandom_range(0, points_on(n, j) - 1);
				send_request(j, p);
			end else begin
				send_request($urandom_range(0, 32767), $urandom_range(0, 32767));
			end
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		run_phase(1, 190, 0);
		tx_quiet = 1;
		rx_quiet = 1;
		run_phase(8192, 240, 1);
		tx_quiet = 0;
		run_phase(2, 190, 0);
		rx_quiet = 0;
		run_phase(3, 190, 0);
		run_phase(0, 60, 0);
		run_phase(16383, 60, 0);
		tx_quiet = 1;
		run_phase(32'hFFFF_C005, 190, 0);
		tx_quiet = 0;
		run_phase(64, 190, 0);
		run_phase($urandom_range(1, 8192), 240, 0);
		run_phase(8192, 240, 0);
		in_valid <= 0;
		repeat (150) @(posedge clk);
		if (!sb.failed && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
rtl/hrpc_pkg.sv
rtl/healpix_ring_point_coordinates.sv
tb/tb_healpix_ring_point_coordinates.sv
